>>> rtl/ppfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and constants of the palette pixel format converter.
// ----------------------------------------------------------------------------
package ppfc_pkg;

	localparam int unsigned MAX_PIXELS = 2097152;

	localparam int ADDR_W  = 23;
	localparam int POS_W   = 21;
	localparam int PLANE_W = 22;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_PLANE  = 1'b1;

	localparam logic [3:0] FMT_CRCGCB   = 4'd0;
	localparam logic [3:0] FMT_CRCGCBDB = 4'd1;
	localparam logic [3:0] FMT_RGB24    = 4'd2;
	localparam logic [3:0] FMT_RGBA32   = 4'd3;
	localparam logic [3:0] FMT_ARGB32   = 4'd4;
	localparam logic [3:0] FMT_CBCGCR   = 4'd5;
	localparam logic [3:0] FMT_CBCGCRDB = 4'd6;
	localparam logic [3:0] FMT_BGR24    = 4'd7;
	localparam logic [3:0] FMT_BGRA32   = 4'd8;
	localparam logic [3:0] FMT_ABGR32   = 4'd9;
	localparam logic [3:0] FMT_GRAY8    = 4'd10;
	localparam logic [3:0] FMT_DEPTH    = 4'd11;
	localparam logic [3:0] FMT_INDEX8   = 4'd12;

	localparam logic [15:0] GRAY_WR = 16'd54;
	localparam logic [15:0] GRAY_WG = 16'd184;
	localparam logic [15:0] GRAY_WB = 16'd18;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

	// Byte writes of one pixel, issued from beat 0 to last_beat.
	typedef struct packed {
		logic [3:0][ADDR_W-1:0] addr;
		logic [3:0][7:0]        val;
		logic [1:0]             last_beat;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic busy;
	} bstat_t;

endpackage

>>> rtl/ppfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_front
// Config registers, palette memory, and per-pixel write list builder.
// ----------------------------------------------------------------------------
module ppfc_front import ppfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [PLANE_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	input  logic [7:0]         in_index,
	input  logic [7:0]         in_red,
	input  logic [7:0]         in_green,
	input  logic [7:0]         in_blue,
	input  logic [POS_W-1:0]   in_pos,
	output logic               push,
	output qent_t              ent,
	input  qstat_t             qstat
);

	logic [3:0]         format_q;
	logic [PLANE_W-1:0] plane_q;

	logic [23:0]        palette_mem [256];
	logic [23:0]        rgb_s1;
	logic [7:0]         idx_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               valid_s1;

	qent_t              ent_s2;
	logic               valid_s2;

	logic               accept;
	logic               s2_en;
	logic               has_out;
	qent_t              ent_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_CRCGCB;
			plane_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT: format_q <= cfg_data[3:0];
				REG_PLANE: begin
					plane_q <= (cfg_data > PLANE_W'(MAX_PIXELS)) ? PLANE_W'(MAX_PIXELS)
					                                              : cfg_data;
				end
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && in_ready;
	assign push     = valid_s2 && !qstat.full;
	assign s2_en    = !valid_s2 || push;
	assign in_ready = !valid_s1 || s2_en;
	assign ent      = ent_s2;

	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_LOAD)
			palette_mem[in_index] <= {in_red, in_green, in_blue};
		if (accept && in_cmd == CMD_PIXEL) begin
			rgb_s1 <= palette_mem[in_index];
			idx_s1 <= in_index;
			pos_s1 <= in_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= accept && in_cmd == CMD_PIXEL;
			if (s2_en)
				valid_s2 <= valid_s1 && has_out;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1)
			ent_s2 <= ent_c;
	end

	logic [7:0]        r, g, b;
	logic [ADDR_W-1:0] pos_a, plane_a, addr_p1, addr_p2, base3, base4, base;
	logic [15:0]       gray_sum;
	logic              packed_fmt, four;
	logic [1:0]        lr, lg, lb, la;

	always_comb begin
		r        = rgb_s1[23:16];
		g        = rgb_s1[15:8];
		b        = rgb_s1[7:0];
		pos_a    = ADDR_W'(pos_s1);
		plane_a  = ADDR_W'(plane_q);
		addr_p1  = pos_a + plane_a;
		addr_p2  = pos_a + {plane_q, 1'b0};
		base3    = pos_a + {1'b0, pos_s1, 1'b0};
		base4    = {pos_s1, 2'b00};
		gray_sum = 16'(r) * GRAY_WR + 16'(g) * GRAY_WG + 16'(b) * GRAY_WB;

		has_out    = 1'b0;
		packed_fmt = 1'b0;
		four       = 1'b0;
		lr = 2'd0; lg = 2'd0; lb = 2'd0; la = 2'd0;
		ent_c      = '0;

		case (format_q)
			FMT_CRCGCB, FMT_CRCGCBDB: begin
				has_out   = 1'b1;
				ent_c.addr[0] = pos_a;
				ent_c.addr[1] = addr_p1;
				ent_c.addr[2] = addr_p2;
				ent_c.val[0] = r; ent_c.val[1] = g; ent_c.val[2] = b;
				ent_c.last_beat = 2'd2;
			end
			FMT_CBCGCR, FMT_CBCGCRDB: begin
				has_out   = 1'b1;
				ent_c.addr[0] = addr_p2;
				ent_c.addr[1] = addr_p1;
				ent_c.addr[2] = pos_a;
				ent_c.val[0] = r; ent_c.val[1] = g; ent_c.val[2] = b;
				ent_c.last_beat = 2'd2;
			end
			FMT_RGB24: begin
				packed_fmt = 1'b1; lr = 2'd2; lg = 2'd1; lb = 2'd0;
			end
			FMT_RGBA32: begin
				packed_fmt = 1'b1; four = 1'b1; lr = 2'd3; lg = 2'd2; lb = 2'd1; la = 2'd0;
			end
			FMT_ARGB32: begin
				packed_fmt = 1'b1; four = 1'b1; lr = 2'd2; lg = 2'd1; lb = 2'd0; la = 2'd3;
			end
			FMT_BGR24: begin
				packed_fmt = 1'b1; lr = 2'd0; lg = 2'd1; lb = 2'd2;
			end
			FMT_BGRA32: begin
				packed_fmt = 1'b1; four = 1'b1; lr = 2'd1; lg = 2'd2; lb = 2'd3; la = 2'd0;
			end
			FMT_ABGR32: begin
				packed_fmt = 1'b1; four = 1'b1; lr = 2'd0; lg = 2'd1; lb = 2'd2; la = 2'd3;
			end
			FMT_GRAY8: begin
				has_out = 1'b1;
				ent_c.addr[0] = pos_a;
				ent_c.val[0]  = gray_sum[15:8];
				ent_c.last_beat = 2'd0;
			end
			FMT_INDEX8: begin
				has_out = 1'b1;
				ent_c.addr[0] = pos_a;
				ent_c.val[0]  = idx_s1;
				ent_c.last_beat = 2'd0;
			end
			default: ;
		endcase

		base = four ? base4 : base3;
		if (packed_fmt) begin
			has_out = 1'b1;
			ent_c.addr[0] = base + ADDR_W'(lr);
			ent_c.addr[1] = base + ADDR_W'(lg);
			ent_c.addr[2] = base + ADDR_W'(lb);
			ent_c.addr[3] = base + ADDR_W'(la);
			ent_c.val[0] = r; ent_c.val[1] = g; ent_c.val[2] = b;
			ent_c.val[3] = ALPHA_OPAQUE;
			ent_c.last_beat = four ? 2'd3 : 2'd2;
		end
	end

endmodule

>>> rtl/ppfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_queue
// Small FIFO of per-pixel write lists between front and back.
// ----------------------------------------------------------------------------
module ppfc_queue import ppfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  wr_ent,
	input  logic   pop,
	output qent_t  rd_ent,
	output qstat_t qstat
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign qstat.empty = cnt_q == '0;
	assign rd_ent      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_ent;
	end

	// QDEPTH is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/ppfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_back
// Beat sequencer: one byte write per cycle into the output reg unless stalled.
// ----------------------------------------------------------------------------
module ppfc_back import ppfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qent_t             head,
	input  qstat_t            qstat,
	output logic              pop,
	output bstat_t            bstat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_addr,
	output logic [7:0]        out_val,
	output logic              out_last
);

	qent_t             cur_q;
	logic              cur_valid_q;
	logic [1:0]        beat_q;
	logic              m_valid_q;
	logic [ADDR_W-1:0] m_addr_q;
	logic [7:0]        m_val_q;
	logic              m_last_q;

	logic out_free, fire, done;

	assign out_free   = !m_valid_q || out_ready;
	assign fire       = cur_valid_q && out_free;
	assign done       = fire && beat_q == cur_q.last_beat;
	assign pop        = !qstat.empty && (!cur_valid_q || done);
	assign bstat.busy = cur_valid_q;

	assign out_valid = m_valid_q;
	assign out_addr  = m_addr_q;
	assign out_val   = m_val_q;
	assign out_last  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			beat_q      <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (out_free)
				m_valid_q <= fire;
			if (pop) begin
				cur_valid_q <= 1'b1;
				beat_q      <= '0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end else if (fire) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (fire) begin
			m_addr_q <= cur_q.addr[beat_q];
			m_val_q  <= cur_q.val[beat_q];
			m_last_q <= beat_q == cur_q.last_beat;
		end
	end

endmodule

>>> rtl/palette_pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_format_converter
// Palette lookup and frame-buffer byte write generation per pixel format.
//
//   channel   dir   handshake                  payload
//   s_axis    in    s_axis_tvalid/tready       tdata, tuser (cmd)
//   m_axis    out   m_axis_tvalid/tready       tdata, tlast
//   cfg       in    cfg_we                     cfg_index, cfg_data
//
// A word is taken every cycle while the write-list queue has room; palette
// loads emit nothing.
// A pixel gives 1, 3 or 4 byte writes (none for FMT_DEPTH or unused codes)
// at one per cycle from the back sequencer unless the output stalls.
// Reset clears config and control only; the palette is undefined until loaded.
// Output stalls fill the 4-deep queue, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module palette_pixel_format_converter import ppfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [PLANE_W-1:0] cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [7:0] color_index, [15:8] red_in, [23:16] green_in, [31:24] blue_in,
	// [52:32] pixel_position, [55:53] zero
	input  logic [55:0]        s_axis_tdata,
	// [0] cmd
	input  logic               s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [22:0] byte_address, [30:23] byte_value, [31] zero
	output logic [31:0]        m_axis_tdata,
	output logic               m_axis_tlast
);

	logic              q_push, q_pop;
	qent_t             q_wr, q_rd;
	qstat_t            qstat;
	bstat_t            bstat;
	logic [ADDR_W-1:0] out_addr;
	logic [7:0]        out_val;

	ppfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_index (s_axis_tdata[7:0]),
		.in_red   (s_axis_tdata[15:8]),
		.in_green (s_axis_tdata[23:16]),
		.in_blue  (s_axis_tdata[31:24]),
		.in_pos   (s_axis_tdata[52:32]),
		.push     (q_push),
		.ent      (q_wr),
		.qstat    (qstat)
	);

	ppfc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_ent(q_wr),
		.pop   (q_pop),
		.rd_ent(q_rd),
		.qstat (qstat)
	);

	ppfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_rd),
		.qstat    (qstat),
		.pop      (q_pop),
		.bstat    (bstat),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_addr (out_addr),
		.out_val  (out_val),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_val, out_addr};

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && qstat.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && qstat.empty))
		else $error("pop from empty queue");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.empty && !bstat.busy && m_axis_tvalid && m_axis_tready)
		|=> !m_axis_tvalid)
		else $error("output word with no pending write list");

	a_last_ends_list: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> bstat.busy)
		else $error("write list ended without last");

endmodule

>>> tb/tb_palette_pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_pixel_format_converter
// Stream testbench for the palette pixel format converter. Palette loads and
// pixel words go in through s_axis; every byte write that leaves m_axis is
// checked against a local prediction of the palette lookup and of the byte
// layout of the selected format. Format and plane size change between phases
// while the block is idle. Both sides idle at random before segment 10.
// ----------------------------------------------------------------------------
module tb_palette_pixel_format_converter;
	import ppfc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int SEG_WORDS = 22;
	localparam logic [3:0] FMT_UNUSED_14 = 4'd14;
	localparam logic [21:0] PLANE_ALL_ONES = 22'h3FFFFF;
	localparam logic [20:0] POS_MAX = 21'h1FFFFF;

	typedef struct {
		logic        cmd;
		logic [7:0]  idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [20:0] pos;
		bit          drain;
	} in_word_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        value;
		logic              last;
	} byte_write_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [PLANE_W-1:0] cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [55:0]        s_axis_tdata;
	logic               s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [31:0]        m_axis_tdata;
	logic               m_axis_tlast;

	palette_pixel_format_converter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	logic [23:0]        palette_mem [256];
	logic [3:0]         cfg_fmt;
	logic [PLANE_W-1:0] cfg_plane;
	byte_write_t        byte_writes_due [$];
	in_word_t           stim_words [$];
	bit                 loaded [256];
	logic [7:0]         loaded_idx [$];
	int                 n_queued;
	int                 n_accepted;
	int                 mismatches;
	int                 cycles;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit                 s_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", field, got, want,
			cycles);
		mismatches++;
	endtask

	task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [7:0] value,
			input logic last);
		byte_write_t bw;
		bw.addr = addr;
		bw.value = value;
		bw.last = last;
		byte_writes_due.push_back(bw);
	endtask

	task automatic predict_word(input logic cmd, input logic [55:0] d);
		logic [7:0]        idx, r, g, b;
		logic [20:0]       pos;
		logic [ADDR_W-1:0] pos_a, plane, plane2, base;
		int                mul, lr, lg, lb, la;
		int unsigned       gray;
		bit                packed_fmt, has_alpha;
		idx = d[7:0];
		pos = d[52:32];
		pos_a = ADDR_W'(pos);
		packed_fmt = 1'b0;
		has_alpha = 1'b0;
		mul = 0; lr = 0; lg = 0; lb = 0; la = 0;
		if (cmd == CMD_LOAD) begin
			palette_mem[idx] = d[31:8];
		end else begin
			r = palette_mem[idx][7:0];
			g = palette_mem[idx][15:8];
			b = palette_mem[idx][23:16];
			plane = (cfg_plane > PLANE_W'(MAX_PIXELS)) ? ADDR_W'(MAX_PIXELS)
			                                            : ADDR_W'(cfg_plane);
			plane2 = {plane[ADDR_W-2:0], 1'b0};
			case (cfg_fmt)
				FMT_CRCGCB, FMT_CRCGCBDB: begin
					push_write(pos_a, r, 1'b0);
					push_write(pos_a + plane, g, 1'b0);
					push_write(pos_a + plane2, b, 1'b1);
				end
				FMT_CBCGCR, FMT_CBCGCRDB: begin
					push_write(pos_a + plane2, r, 1'b0);
					push_write(pos_a + plane, g, 1'b0);
					push_write(pos_a, b, 1'b1);
				end
				FMT_RGB24: begin
					packed_fmt = 1; mul = 3; lr = 2; lg = 1; lb = 0;
				end
				FMT_RGBA32: begin
					packed_fmt = 1; mul = 4; lr = 3; lg = 2; lb = 1; la = 0; has_alpha = 1;
				end
				FMT_ARGB32: begin
					packed_fmt = 1; mul = 4; lr = 2; lg = 1; lb = 0; la = 3; has_alpha = 1;
				end
				FMT_BGR24: begin
					packed_fmt = 1; mul = 3; lr = 0; lg = 1; lb = 2;
				end
				FMT_BGRA32: begin
					packed_fmt = 1; mul = 4; lr = 1; lg = 2; lb = 3; la = 0; has_alpha = 1;
				end
				FMT_ABGR32: begin
					packed_fmt = 1; mul = 4; lr = 0; lg = 1; lb = 2; la = 3; has_alpha = 1;
				end
				FMT_GRAY8: begin
					gray = (int'(GRAY_WR) * r + int'(GRAY_WG) * g + int'(GRAY_WB) * b) >> 8;
					push_write(pos_a, gray[7:0], 1'b1);
				end
				FMT_INDEX8: push_write(pos_a, idx, 1'b1);
				default: ;
			endcase
			if (packed_fmt) begin
				base = ADDR_W'(int'(pos) * mul);
				push_write(base + ADDR_W'(lr), r, 1'b0);
				push_write(base + ADDR_W'(lg), g, 1'b0);
				push_write(base + ADDR_W'(lb), b, !has_alpha);
				if (has_alpha)
					push_write(base + ADDR_W'(la), ALPHA_OPAQUE, 1'b1);
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [PLANE_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FORMAT)
			cfg_fmt = data[3:0];
		else
			cfg_plane = data;
	endtask

	task automatic settle_block();
		while (n_accepted != n_queued || byte_writes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_word(input logic cmd, input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [20:0] pos, input bit drain);
		in_word_t w;
		w.cmd = cmd;
		w.idx = idx;
		w.red = r;
		w.green = g;
		w.blue = b;
		w.pos = pos;
		w.drain = drain;
		if (cmd == CMD_LOAD && !loaded[idx]) begin
			loaded[idx] = 1;
			loaded_idx.push_back(idx);
		end
		stim_words.push_back(w);
		n_queued++;
	endtask

	task automatic queue_random_words(input int n);
		logic [7:0]  idx;
		logic [20:0] pos;
		bit          is_load;
		for (int i = 0; i < n; i++) begin
			is_load = loaded_idx.size() == 0 || $urandom_range(0, 99) < 25;
			if (is_load)
				idx = 8'($urandom_range(0, 255));
			else
				idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
			case ($urandom_range(0, 9))
				0: pos = '0;
				1: pos = POS_MAX;
				default: pos = 21'($urandom);
			endcase
			queue_word(is_load ? CMD_LOAD : CMD_PIXEL, idx, 8'($urandom), 8'($urandom),
				8'($urandom), pos, $urandom_range(0, 99) < 3);
		end
	endtask

	// stream sender and receiver
	always @(negedge clk) begin
		in_word_t w;
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		if (!s_axis_tvalid || s_taken) begin
			if (stim_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
					!(stim_words[0].drain && byte_writes_due.size() != 0)) begin
				w = stim_words.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b000, w.pos, w.blue, w.green, w.red, w.idx};
				s_axis_tuser <= w.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check leaving byte writes, then predict from the accepted word
	always @(posedge clk) begin
		byte_write_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (byte_writes_due.size() == 0) begin
					report_mismatch("unexpected word", m_axis_tdata, '0);
				end else begin
					want = byte_writes_due.pop_front();
					if (m_axis_tdata[22:0] !== want.addr)
						report_mismatch("byte_address", 32'(m_axis_tdata[22:0]),
							32'(want.addr));
					if (m_axis_tdata[30:23] !== want.value)
						report_mismatch("byte_value", 32'(m_axis_tdata[30:23]),
							32'(want.value));
					if (m_axis_tlast !== want.last)
						report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
				end
			end
			s_taken = s_axis_tvalid && s_axis_tready;
			if (s_taken) begin
				n_accepted++;
				predict_word(s_axis_tuser, s_axis_tdata);
			end
		end else begin
			s_taken = 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("FAIL palette_pixel_format_converter");
			$finish;
		end
	end

	initial begin
		logic [3:0]         fmt_seq [14];
		logic [3:0]         f;
		logic [PLANE_W-1:0] plane;
		logic [7:0]         dir_idx;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOAD;
		m_axis_tready = 1'b0;
		cfg_fmt = FMT_CRCGCB;
		cfg_plane = '0;
		for (int i = 0; i < 256; i++)
			palette_mem[i] = '0;
		n_queued = 0;
		n_accepted = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 23;
		recv_idle_pct = 86;
		fmt_seq = '{FMT_RGBA32, FMT_CRCGCB, FMT_INDEX8, FMT_CBCGCR, FMT_ABGR32, FMT_GRAY8,
			FMT_RGB24, FMT_ARGB32, FMT_BGR24, FMT_BGRA32, FMT_CRCGCBDB, FMT_CBCGCRDB,
			FMT_DEPTH, FMT_UNUSED_14};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extreme colors, reset config, then every format once
		queue_word(CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, '0, 0);
		queue_word(CMD_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, POS_MAX, 0);
		queue_word(CMD_LOAD, 8'd1, 8'd255, 8'd0, 8'd0, '0, 0);
		queue_word(CMD_LOAD, 8'd2, 8'd0, 8'd255, 8'd0, '0, 0);
		queue_word(CMD_LOAD, 8'd3, 8'd0, 8'd0, 8'd255, '0, 0);
		queue_word(CMD_LOAD, 8'd170, 8'hAA, 8'h55, 8'hC3, 21'h0AAAAA, 0);
		queue_word(CMD_PIXEL, 8'd170, 8'hFF, 8'hFF, 8'hFF, 21'h155555, 0);
		settle_block();
		write_reg(REG_PLANE, PLANE_ALL_ONES);
		for (int i = 0; i < 16; i++) begin
			f = 4'(i);
			write_reg(REG_FORMAT, {18'h3FFFF, f});
			dir_idx = (f == FMT_GRAY8) ? 8'd255 : (f[0] ? 8'd170 : {6'd0, f[2:1]});
			queue_word(CMD_PIXEL, dir_idx, '0, '0, '0, f[1] ? POS_MAX : 21'd0, 0);
			settle_block();
		end

		// random segments, one setting each
		for (int s = 0; s < 14; s++) begin
			if (s == 5) begin
				send_idle_pct = 86;
				recv_idle_pct = 23;
			end else if (s == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(0, 5))
				0: plane = '0;
				1: plane = 22'd1;
				2: plane = PLANE_W'($urandom_range(0, 4096));
				3: plane = PLANE_W'(MAX_PIXELS);
				4: plane = PLANE_ALL_ONES;
				default: plane = PLANE_W'($urandom);
			endcase
			write_reg(REG_FORMAT, {18'($urandom), fmt_seq[s]});
			write_reg(REG_PLANE, plane);
			queue_random_words(SEG_WORDS);
			settle_block();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASS palette_pixel_format_converter");
		else
			$display("FAIL palette_pixel_format_converter");
		$finish;
	end

endmodule
